// ===== rtl/ovle_pkg.sv =====
package ovle_pkg;

	// List geometry
	localparam int CAPACITY    = 64;
	localparam int MAX_RESULTS = 64;
	localparam int DUMP_MAX    = (MAX_RESULTS < CAPACITY) ? MAX_RESULTS : CAPACITY;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	// Transaction field widths
	localparam int OP_W    = 3;
	localparam int VAL_W   = 32;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_SEARCH = 3'd1,
		OP_DELETE = 3'd2,
		OP_MODIFY = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_DUMP   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		status_t                   status;
		logic [POS_W-1:0]          position;
		logic signed [VAL_W-1:0]   entry_value;
		logic [COUNT_W-1:0]        entry_count;
		logic                      last;
	} rsp_t;

endpackage

// ===== rtl/ovle_if.sv =====
interface ovle_req_if import ovle_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic signed [VAL_W-1:0] data;
	logic signed [VAL_W-1:0] new_value;

	modport source(output valid, output op, output data, output new_value, input ready);
	modport sink(input valid, input op, input data, input new_value, output ready);
endinterface

interface ovle_rsp_if import ovle_pkg::*; ();
	logic                    valid;
	logic                    ready;
	status_t                 status;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] entry_value;
	logic [COUNT_W-1:0]      entry_count;
	logic                    last;

	modport source(output valid, output status, output position, output entry_value,
		output entry_count, output last, input ready);
	modport sink(input valid, input status, input position, input entry_value,
		input entry_count, input last, output ready);
endinterface

// ===== rtl/ovle_ram.sv =====
module ovle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read data holds until the next read enable.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ordered_value_list_engine_top.sv =====
// Operation: append and clear go straight to the response register; search and modify
//   walk the entries from position 0 up to the match (the whole list on a miss); delete
//   adds a gap-closing shift of the entries past the match; a dump streams one entry per
//   cycle unless the output stalls. Only one request is taken at a time; the walk through
//   the entry RAM (one read per cycle) and output stalls set how long an operation takes.
// Reset: arst_n clears the entry count, sequencer and output valid; entry RAM is not cleared.
module ordered_value_list_engine_top import ovle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ovle_req_if.sink  req,
	ovle_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DUMP,
		S_RESP
	} state_t;

	state_t            state_q;
	logic [OP_W-1:0]   op_q;
	logic [VAL_W-1:0]  key_q;
	logic [VAL_W-1:0]  nv_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              v_s1;
	logic [IDX_W-1:0]  idx_s1;
	rsp_t              resp_q;
	rsp_t              out_q;
	logic              out_valid_q;

	// Entry RAM port signals
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [VAL_W-1:0]  ram_rdata;

	// Sequencer helpers
	logic              accept;
	logic              out_free;
	logic              full;
	logic              scan_hit;
	logic              more;
	logic              dump_take;
	logic              dump_last;
	logic [CNT_W-1:0]  dump_n;
	logic [CNT_W-1:0]  bound;
	logic [CNT_W-1:0]  count_inc;
	logic [CNT_W-1:0]  count_dec;

	ovle_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ptr_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// Requests are taken only between operations; the response register decouples the sink.
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign count_inc = count_q + 1'b1;
	assign count_dec = count_q - 1'b1;

	// A dump never gives more than DUMP_MAX transactions.
	assign dump_n    = (count_q > CNT_W'(DUMP_MAX)) ? CNT_W'(DUMP_MAX) : count_q;
	assign bound     = (state_q == S_DUMP) ? dump_n : count_q;
	assign more      = (ptr_q < bound);

	// Stage s1 holds the entry last read from the RAM; the shared comparator checks it.
	assign scan_hit  = (state_q == S_SCAN) && v_s1 && (ram_rdata == key_q);
	assign dump_take = (state_q == S_DUMP) && v_s1 && out_free;
	assign dump_last = ((CNT_W'(idx_s1) + 1'b1) == dump_n);

	// Read issue: one RAM read per cycle while walking; a dump only reads ahead when the
	// entry already in flight leaves for the output this cycle (RAM data holds otherwise).
	always_comb begin
		case (state_q)
			S_SCAN:  ram_re = more && !scan_hit;
			S_SHIFT: ram_re = more;
			S_DUMP:  ram_re = more && (!v_s1 || out_free);
			default: ram_re = 1'b0;
		endcase
	end

	// Write port: append at the tail, overwrite on modify, move each entry down one on delete.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = req.data;
		case (state_q)
			S_IDLE: begin
				ram_we = accept && (req.op == OP_APPEND) && !full;
			end
			S_SCAN: begin
				ram_we    = scan_hit && (op_q == OP_MODIFY);
				ram_waddr = idx_s1;
				ram_wdata = nv_q;
			end
			S_SHIFT: begin
				ram_we    = v_s1;
				ram_waddr = idx_s1 - 1'b1;
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.position    = out_q.position;
	assign rsp.entry_value = out_q.entry_value;
	assign rsp.entry_count = out_q.entry_count;
	assign rsp.last        = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the response once the sink takes it; a new load below wins.
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			// Advance the read pipeline.
			if (ram_re) begin
				v_s1   <= 1'b1;
				idx_s1 <= ptr_q[IDX_W-1:0];
				ptr_q  <= ptr_q + 1'b1;
			end else if (state_q != S_DUMP || dump_take) begin
				v_s1 <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= req.op;
						key_q <= req.data;
						nv_q  <= req.new_value;
						ptr_q <= '0;
						case (req.op)
							OP_APPEND: begin
								state_q <= S_RESP;
								if (full) begin
									resp_q <= '{status: ST_FULL, position: '0, entry_value: '0,
										entry_count: COUNT_W'(count_q), last: 1'b1};
								end else begin
									count_q <= count_inc;
									resp_q  <= '{status: ST_OK, position: POS_W'(count_q),
										entry_value: req.data, entry_count: COUNT_W'(count_inc),
										last: 1'b1};
								end
							end
							OP_SEARCH, OP_DELETE, OP_MODIFY: begin
								if (count_q == '0) begin
									state_q <= S_RESP;
									resp_q  <= '{status: ST_NOT_FOUND, position: '0,
										entry_value: '0, entry_count: '0, last: 1'b1};
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_RESP;
								resp_q  <= '{status: ST_OK, position: '0, entry_value: '0,
									entry_count: '0, last: 1'b1};
							end
							OP_DUMP: begin
								if (count_q == '0) begin
									state_q <= S_RESP;
									resp_q  <= '{status: ST_EMPTY, position: '0,
										entry_value: '0, entry_count: '0, last: 1'b1};
								end else begin
									state_q <= S_DUMP;
								end
							end
							default: begin
								// Unused codes: ignore the transaction.
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_SCAN: begin
					if (scan_hit) begin
						case (op_q)
							OP_DELETE: begin
								// Close the gap: start moving entries from just past the match.
								ptr_q   <= CNT_W'(idx_s1) + 1'b1;
								state_q <= S_SHIFT;
								resp_q  <= '{status: ST_OK, position: POS_W'(idx_s1),
									entry_value: ram_rdata, entry_count: COUNT_W'(count_dec),
									last: 1'b1};
							end
							OP_MODIFY: begin
								state_q <= S_RESP;
								resp_q  <= '{status: ST_OK, position: POS_W'(idx_s1),
									entry_value: nv_q, entry_count: COUNT_W'(count_q),
									last: 1'b1};
							end
							default: begin
								state_q <= S_RESP;
								resp_q  <= '{status: ST_OK, position: POS_W'(idx_s1),
									entry_value: ram_rdata, entry_count: COUNT_W'(count_q),
									last: 1'b1};
							end
						endcase
					end else if (!more && !v_s1) begin
						state_q <= S_RESP;
						resp_q  <= '{status: ST_NOT_FOUND, position: '0, entry_value: '0,
							entry_count: COUNT_W'(count_q), last: 1'b1};
					end
				end

				S_SHIFT: begin
					// Last move written: shrink the list (tail moves back by one).
					if (!more && !v_s1) begin
						count_q <= count_dec;
						state_q <= S_RESP;
					end
				end

				S_DUMP: begin
					if (dump_take) begin
						out_valid_q <= 1'b1;
						out_q       <= '{status: ST_OK, position: POS_W'(idx_s1),
							entry_value: ram_rdata, entry_count: COUNT_W'(count_q),
							last: dump_last};
						if (dump_last) begin
							state_q <= S_IDLE;
						end
					end
				end

				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= resp_q;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
